### hw/rtl/adfs_pkg.sv
package adfs_pkg;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NAME = 2'd1;
    localparam logic [1:0] KIND_UUID = 2'd2;

    localparam logic [7:0] AD_UUID16_PART = 8'h02;
    localparam logic [7:0] AD_UUID16_FULL = 8'h03;
    localparam logic [7:0] AD_NAME_SHORT  = 8'h08;
    localparam logic [7:0] AD_NAME_FULL   = 8'h09;

    localparam logic [6:0] FIELD_COUNT_MAX = 7'd127;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic [6:0] field_count;
        logic       truncated;
        logic       name_found;
        logic [7:0] name_offset;
        logic [7:0] name_length;
        logic       uuid_found;
        logic [7:0] uuid_offset;
        logic [6:0] uuid_count;
    } t_summary;

endpackage

### hw/rtl/adfs_stream_if.sv
interface adfs_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/adfs_parse_core.sv
module adfs_parse_core
    import adfs_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_fire,
    input  t_in_word i_word,
    output t_summary o_summary
);

    localparam int PW = $clog2(MAX_PAYLOAD + 1);

    logic [PW-1:0] r_pos,     n_pos;
    logic [1:0]    r_phase,   n_phase;
    logic [1:0]    r_kind,    n_kind;
    logic [7:0]    r_start,   n_start;
    logic [7:0]    r_dlen,    n_dlen;
    logic [7:0]    r_remain,  n_remain;
    logic [6:0]    r_fields,  n_fields;
    logic          r_trunc,   n_trunc;
    logic          r_name,    n_name;
    logic [7:0]    r_name_st, n_name_st;
    logic [7:0]    r_name_ln, n_name_ln;
    logic          r_uuid,    n_uuid;
    logic [7:0]    r_uuid_st, n_uuid_st;
    logic [6:0]    r_uuid_ct, n_uuid_ct;

    logic [PW+7:0] pos_ext;
    logic [7:0]    b;
    logic          last;
    logic          finish;
    logic [1:0]    kind_now;
    logic [1:0]    type_kind;

    assign pos_ext = {8'd0, r_pos};
    assign b       = i_word.payload_byte;
    assign last    = i_word.last_byte;

    always_comb begin
        if (b == AD_NAME_SHORT || b == AD_NAME_FULL) begin
            type_kind = KIND_NAME;
        end else if (b == AD_UUID16_PART || b == AD_UUID16_FULL) begin
            type_kind = KIND_UUID;
        end else begin
            type_kind = KIND_NONE;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_start   = r_start;
        n_dlen    = r_dlen;
        n_remain  = r_remain;
        n_fields  = r_fields;
        n_trunc   = r_trunc;
        n_name    = r_name;
        n_name_st = r_name_st;
        n_name_ln = r_name_ln;
        n_uuid    = r_uuid;
        n_uuid_st = r_uuid_st;
        n_uuid_ct = r_uuid_ct;
        finish    = 1'b0;
        kind_now  = r_kind;

        if (r_pos >= PW'(MAX_PAYLOAD)) begin
            if (r_phase != PH_STOP) begin
                n_trunc = 1'b1;
            end
            n_phase = PH_STOP;
        end else begin
            case (r_phase)
                PH_LEN: begin
                    if (!last) begin
                        if (b == 8'd0) begin
                            n_trunc = 1'b1;
                            n_phase = PH_STOP;
                        end else begin
                            n_start  = pos_ext[7:0];
                            n_dlen   = b - 8'd1;
                            n_remain = b - 8'd1;
                            n_phase  = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    kind_now = type_kind;
                    n_kind   = type_kind;
                    if (r_remain == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_remain = r_remain - 8'd1;
                        n_phase  = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (r_remain == 8'd0) begin
                        finish = 1'b1;
                    end else begin
                        n_remain = r_remain - 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (finish) begin
            if (r_fields != FIELD_COUNT_MAX) begin
                n_fields = r_fields + 7'd1;
            end
            if (kind_now == KIND_NAME) begin
                n_name    = 1'b1;
                n_name_st = r_start + 8'd2;
                n_name_ln = r_dlen;
            end else if (kind_now == KIND_UUID) begin
                n_uuid    = 1'b1;
                n_uuid_st = r_start + 8'd2;
                n_uuid_ct = r_dlen[7:1];
            end
            n_kind  = KIND_NONE;
            n_phase = PH_LEN;
        end

        if (last && (n_phase == PH_TYPE || n_phase == PH_DATA)) begin
            n_trunc = 1'b1;
            n_phase = PH_STOP;
        end

        if (r_pos != PW'(MAX_PAYLOAD)) begin
            n_pos = r_pos + PW'(1);
        end
    end

    always_comb begin
        o_summary.field_count = n_fields;
        o_summary.truncated   = n_trunc;
        o_summary.name_found  = n_name;
        o_summary.name_offset = n_name ? n_name_st : 8'd0;
        o_summary.name_length = n_name ? n_name_ln : 8'd0;
        o_summary.uuid_found  = n_uuid;
        o_summary.uuid_offset = n_uuid ? n_uuid_st : 8'd0;
        o_summary.uuid_count  = n_uuid ? n_uuid_ct : 7'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && last)) begin
            r_pos     <= '0;
            r_phase   <= PH_LEN;
            r_kind    <= KIND_NONE;
            r_start   <= '0;
            r_dlen    <= '0;
            r_remain  <= '0;
            r_fields  <= '0;
            r_trunc   <= 1'b0;
            r_name    <= 1'b0;
            r_name_st <= '0;
            r_name_ln <= '0;
            r_uuid    <= 1'b0;
            r_uuid_st <= '0;
            r_uuid_ct <= '0;
        end else if (i_fire) begin
            r_pos     <= n_pos;
            r_phase   <= n_phase;
            r_kind    <= n_kind;
            r_start   <= n_start;
            r_dlen    <= n_dlen;
            r_remain  <= n_remain;
            r_fields  <= n_fields;
            r_trunc   <= n_trunc;
            r_name    <= n_name;
            r_name_st <= n_name_st;
            r_name_ln <= n_name_ln;
            r_uuid    <= n_uuid;
            r_uuid_st <= n_uuid_st;
            r_uuid_ct <= n_uuid_ct;
        end
    end

endmodule

### hw/rtl/adfs_out_reg.sv
module adfs_out_reg
    import adfs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_load,
    input  t_summary i_word,
    output logic     o_space,
    adfs_stream_if.source o_out
);

    logic     r_valid;
    t_summary r_word;

    assign o_space     = !r_valid || o_out.ready;
    assign o_out.valid = r_valid;
    assign o_out.data  = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_word <= i_word;
        end
    end

endmodule

### hw/rtl/adv_data_field_salvage_parser.sv
// Advertising data parser: takes one payload byte per cycle, sustained, with
// no gaps between payloads. Each byte passes an input register and is parsed
// in a single step; a payload's summary is loaded into an output register
// as its last byte leaves the input register and is held there until
// taken, while the next payload's bytes keep flowing in. Only a summary that
// waits on a stalled output holds back a following last byte.
module adv_data_field_salvage_parser
    import adfs_pkg::*;
#(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic i_clk,
    input  logic i_rst_n,
    adfs_stream_if.sink   i_in,
    adfs_stream_if.source o_out
);

    logic     r_in_valid;
    t_in_word r_in_word;
    logic     out_space;
    logic     advance;
    logic     load;
    t_summary summary;

    assign advance  = r_in_valid && (!r_in_word.last_byte || out_space);
    assign load     = advance && r_in_word.last_byte;
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.data;
        end
    end

    adfs_parse_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (advance),
        .i_word    (r_in_word),
        .o_summary (summary)
    );

    adfs_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_word  (summary),
        .o_space (out_space),
        .o_out   (o_out)
    );

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> o_out.valid)
        else $error("last word did not produce a summary");

    a_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.name_found) |->
            (o_out.data.name_offset == 8'd0 && o_out.data.name_length == 8'd0))
        else $error("name fields set without a name");

    a_uuid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.data.uuid_found) |->
            (o_out.data.uuid_offset == 8'd0 && o_out.data.uuid_count == 7'd0))
        else $error("uuid fields set without a uuid list");

    a_middle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid && !load) |=> !o_out.valid)
        else $error("summary appeared without a last word");

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import adfs_pkg::*;

    localparam int MAX_PAYLOAD = 255;
    localparam int BYTE_BUDGET = 1950;
    localparam int HOLD_AT = 700;
    localparam int CALM_AT = 1600;
    localparam int HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT = 500000;
    localparam int N_DIRECTED = 24;

    localparam t_summary ALL_CLEAR = '0;

    typedef struct packed {
        logic [7:0] b;
        logic       last;
        logic       typed;
        t_summary   want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    adfs_stream_if #(.t_payload(t_in_word)) byte_if ();
    adfs_stream_if #(.t_payload(t_summary)) sum_if ();

    adv_data_field_salvage_parser #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (sum_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_row directed_rows [N_DIRECTED] = '{
        {8'h05, 1'b1, 1'b1, ALL_CLEAR},
        {8'hFF, 1'b1, 1'b1, ALL_CLEAR},
        {8'h00, 1'b0, 1'b0, ALL_CLEAR},
        {8'h11, 1'b1, 1'b1, {7'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0}},
        {8'h01, 1'b0, 1'b0, ALL_CLEAR},
        {AD_NAME_FULL, 1'b1, 1'b1, {7'd1, 1'b0, 1'b1, 8'd2, 8'd0, 1'b0, 8'd0, 7'd0}},
        {8'h04, 1'b0, 1'b0, ALL_CLEAR},
        {AD_UUID16_FULL, 1'b0, 1'b0, ALL_CLEAR},
        {8'hAA, 1'b0, 1'b0, ALL_CLEAR},
        {8'h55, 1'b0, 1'b0, ALL_CLEAR},
        {8'hCC, 1'b1, 1'b1, {7'd1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 8'd2, 7'd1}},
        {8'h05, 1'b0, 1'b0, ALL_CLEAR},
        {AD_NAME_SHORT, 1'b0, 1'b0, ALL_CLEAR},
        {8'h41, 1'b1, 1'b1, {7'd0, 1'b1, 1'b0, 8'd0, 8'd0, 1'b0, 8'd0, 7'd0}},
        {8'h02, 1'b0, 1'b0, ALL_CLEAR},
        {AD_NAME_SHORT, 1'b0, 1'b0, ALL_CLEAR},
        {8'h41, 1'b0, 1'b0, ALL_CLEAR},
        {8'h03, 1'b0, 1'b0, ALL_CLEAR},
        {AD_NAME_FULL, 1'b0, 1'b0, ALL_CLEAR},
        {8'h42, 1'b0, 1'b0, ALL_CLEAR},
        {8'h43, 1'b1, 1'b1, {7'd2, 1'b0, 1'b1, 8'd5, 8'd2, 1'b0, 8'd0, 7'd0}},
        {8'h01, 1'b0, 1'b0, ALL_CLEAR},
        {AD_UUID16_PART, 1'b0, 1'b0, ALL_CLEAR},
        {8'hFF, 1'b1, 1'b1, {7'd1, 1'b0, 1'b0, 8'd0, 8'd0, 1'b1, 8'd2, 7'd0}}
    };

    // parser shadow state
    logic [7:0] cur_pos;
    logic [1:0] phase;
    logic [7:0] ad_start;
    logic [8:0] ad_end;
    logic [1:0] ad_kind;
    logic [6:0] ad_total;
    logic       stop_seen;
    logic       name_seen;
    logic [7:0] name_at;
    logic [7:0] name_size;
    logic       uuid_seen;
    logic [7:0] uuid_at;
    logic [6:0] uuid_cnt;

    t_summary   pending_summaries [$];
    logic [7:0] pl_bytes [$];

    int  n_bytes;
    int  n_errors;
    int  n_summaries;
    int  n_trunc;
    int  n_named;
    int  n_uuid;
    int  cycles;
    int  idle_pct;
    bit  calm;
    bit  hold_req;
    bit  hold_done;

    function automatic void clear_parser();
        cur_pos = '0;
        phase = PH_LEN;
        ad_start = '0;
        ad_end = '0;
        ad_kind = KIND_NONE;
        ad_total = '0;
        stop_seen = 1'b0;
        name_seen = 1'b0;
        name_at = '0;
        name_size = '0;
        uuid_seen = 1'b0;
        uuid_at = '0;
        uuid_cnt = '0;
    endfunction

    function automatic bit advance_parse(input t_in_word w, output t_summary s);
        logic [7:0] b;
        logic       last;
        logic [8:0] dlen;
        bit         done;
        b = w.payload_byte;
        last = w.last_byte;
        done = 1'b0;
        s = '0;
        if (int'(cur_pos) >= MAX_PAYLOAD) begin
            if (phase != PH_STOP) stop_seen = 1'b1;
            phase = PH_STOP;
        end else if (phase == PH_LEN) begin
            if (!last) begin
                if (b == 8'd0) begin
                    stop_seen = 1'b1;
                    phase = PH_STOP;
                end else begin
                    ad_start = cur_pos;
                    ad_end = {1'b0, cur_pos} + {1'b0, b};
                    phase = PH_TYPE;
                end
            end
        end else if (phase == PH_TYPE) begin
            if (b == AD_NAME_SHORT || b == AD_NAME_FULL)
                ad_kind = KIND_NAME;
            else if (b == AD_UUID16_PART || b == AD_UUID16_FULL)
                ad_kind = KIND_UUID;
            else
                ad_kind = KIND_NONE;
            if ({1'b0, cur_pos} == ad_end) done = 1'b1;
            else phase = PH_DATA;
        end else if (phase == PH_DATA) begin
            if ({1'b0, cur_pos} == ad_end) done = 1'b1;
        end
        if (done) begin
            dlen = ad_end - {1'b0, ad_start} - 9'd1;
            if (ad_total != FIELD_COUNT_MAX) ad_total = ad_total + 7'd1;
            if (ad_kind == KIND_NAME) begin
                name_seen = 1'b1;
                name_at = ad_start + 8'd2;
                name_size = dlen[7:0];
            end else if (ad_kind == KIND_UUID) begin
                uuid_seen = 1'b1;
                uuid_at = ad_start + 8'd2;
                uuid_cnt = dlen[7:1];
            end
            ad_kind = KIND_NONE;
            phase = PH_LEN;
        end
        if (last && (phase == PH_TYPE || phase == PH_DATA)) begin
            stop_seen = 1'b1;
            phase = PH_STOP;
        end
        if (cur_pos != 8'hFF) cur_pos = cur_pos + 8'd1;
        if (!last) return 1'b0;
        s.field_count = ad_total;
        s.truncated = stop_seen;
        s.name_found = name_seen;
        s.name_offset = name_seen ? name_at : 8'd0;
        s.name_length = name_seen ? name_size : 8'd0;
        s.uuid_found = uuid_seen;
        s.uuid_offset = uuid_seen ? uuid_at : 8'd0;
        s.uuid_count = uuid_seen ? uuid_cnt : 7'd0;
        clear_parser();
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1: return AD_NAME_FULL;
            2:    return AD_NAME_SHORT;
            3, 4: return AD_UUID16_FULL;
            5:    return AD_UUID16_PART;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void make_payload();
        int mode;
        int target;
        int len;
        int r;
        pl_bytes.delete();
        mode = $urandom_range(0, 99);
        if (mode < 3) begin
            repeat ($urandom_range(120, 135)) begin
                pl_bytes.push_back(8'd1);
                pl_bytes.push_back(pick_type());
            end
        end else if (mode >= 78) begin
            repeat ($urandom_range(1, 12)) pl_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            target = (mode < 8) ? $urandom_range(240, 300) : $urandom_range(2, 40);
            while (pl_bytes.size() < target) begin
                r = $urandom_range(0, 99);
                len = (r < 70) ? $urandom_range(1, 8) :
                      (r < 92) ? $urandom_range(9, 30) : $urandom_range(31, 255);
                pl_bytes.push_back(8'(len));
                pl_bytes.push_back(pick_type());
                repeat (len - 1) pl_bytes.push_back(8'($urandom_range(0, 255)));
            end
            case ($urandom_range(0, 9))
                0, 1: pl_bytes.push_back(8'($urandom_range(0, 255)));
                2, 3: begin
                    repeat ($urandom_range(1, (pl_bytes.size() > 5) ? 5 : pl_bytes.size() - 1))
                        void'(pl_bytes.pop_back());
                end
                4: begin
                    pl_bytes.push_back(8'd0);
                    repeat ($urandom_range(1, 5)) pl_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: ;
            endcase
        end
    endfunction

    task automatic send_byte(input t_in_word w, input bit typed, input t_summary want);
        t_summary got;
        if (!calm && idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            byte_if.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        byte_if.valid <= 1'b1;
        byte_if.data <= w;
        do @(posedge i_clk); while (!byte_if.ready);
        if (advance_parse(w, got)) pending_summaries.push_back(typed ? want : got);
        n_bytes++;
        @(negedge i_clk);
    endtask

    function automatic void check_field(string fname, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", fname, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : sum_monitor
        t_summary want;
        t_summary got;
        if (i_rst_n && sum_if.valid && sum_if.ready) begin
            got = sum_if.data;
            if (pending_summaries.size() == 0) begin
                $error("summary with no payload pending: %h", got);
                n_errors++;
            end else begin
                want = pending_summaries.pop_front();
                check_field("field_count", want.field_count, got.field_count);
                check_field("truncated", want.truncated, got.truncated);
                check_field("name_found", want.name_found, got.name_found);
                check_field("name_offset", want.name_offset, got.name_offset);
                check_field("name_length", want.name_length, got.name_length);
                check_field("uuid_found", want.uuid_found, got.uuid_found);
                check_field("uuid_offset", want.uuid_offset, got.uuid_offset);
                check_field("uuid_count", want.uuid_count, got.uuid_count);
                n_summaries++;
                if (want.truncated) n_trunc++;
                if (want.name_found) n_named++;
                if (want.uuid_found) n_uuid++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("adv_data_field_salvage_parser regression: fail");
            $finish;
        end
    end

    // output side: random stalls, one long hold
    initial begin
        int stall_left;
        int sink_pct;
        int stretch;
        stall_left = 0;
        sink_pct = 10;
        stretch = 0;
        sum_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stretch++;
            if (stretch >= 150) begin
                stretch = 0;
                case ($urandom_range(0, 2))
                    0: sink_pct = 0;
                    1: sink_pct = 6;
                    default: sink_pct = 20;
                endcase
            end
            if (!i_rst_n) begin
                sum_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                sum_if.ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                sum_if.ready <= 1'b0;
            end else if (!calm && sink_pct != 0 && $urandom_range(1, 100) <= sink_pct) begin
                stall_left = $urandom_range(0, 17);
                sum_if.ready <= 1'b0;
            end else begin
                sum_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_in_word w;
        byte_if.valid = 1'b0;
        byte_if.data = '0;
        clear_parser();
        idle_pct = 20;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            w.payload_byte = directed_rows[i].b;
            w.last_byte = directed_rows[i].last;
            send_byte(w, directed_rows[i].typed, directed_rows[i].want);
        end

        while (n_bytes < BYTE_BUDGET) begin
            make_payload();
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 8;
                default: idle_pct = 25;
            endcase
            if (n_bytes >= HOLD_AT) hold_req = 1'b1;
            if (n_bytes >= CALM_AT) calm = 1'b1;
            foreach (pl_bytes[i]) begin
                w.payload_byte = pl_bytes[i];
                w.last_byte = (i == pl_bytes.size() - 1);
                send_byte(w, 1'b0, ALL_CLEAR);
            end
        end
        byte_if.valid <= 1'b0;

        while (pending_summaries.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("%0d payload bytes sent, %0d summaries checked in %0d cycles",
                 n_bytes, n_summaries, cycles);
        $display("%0d truncated, %0d with a local name, %0d with a UUID list",
                 n_trunc, n_named, n_uuid);
        if (n_errors == 0) begin
            $display("adv_data_field_salvage_parser regression: pass");
        end else begin
            $display("adv_data_field_salvage_parser regression: fail");
        end
        $finish;
    end

endmodule
